// ===== rtl/core/tcce_pkg.sv =====
`timescale 1ns / 1ps

package tcce_pkg;

   // default geometry
   localparam int COLUMNS_DEF     = 80;
   localparam int ROWS_DEF        = 25;
   localparam int TAB_STOP_DEF    = 8;
   localparam int QUEUE_DEPTH_DEF = 4;

   // cursor widths cover the largest supported geometry (128 x 64)
   localparam int COL_W = 7;
   localparam int ROW_W = 6;

   // field widths
   localparam int CMD_W     = 3;
   localparam int CHAR_W    = 8;
   localparam int POS_W     = 8;
   localparam int ATTR_W    = 8;
   localparam int CELL_W    = ATTR_W + CHAR_W;
   localparam int OUT_COL_W = 7;
   localparam int OUT_ROW_W = 5;
   localparam int OUT_LIN_W = 11;

   // command codes
   localparam logic [CMD_W-1:0] CMD_PUT    = 3'd0;
   localparam logic [CMD_W-1:0] CMD_SETPOS = 3'd1;
   localparam logic [CMD_W-1:0] CMD_CLEAR  = 3'd2;
   localparam logic [CMD_W-1:0] CMD_INSERT = 3'd3;
   localparam logic [CMD_W-1:0] CMD_DELETE = 3'd4;
   localparam logic [CMD_W-1:0] CMD_READ   = 3'd5;

   // control characters
   localparam logic [CHAR_W-1:0] CH_BACKSPACE = 8'd8;
   localparam logic [CHAR_W-1:0] CH_TAB       = 8'd9;
   localparam logic [CHAR_W-1:0] CH_NEWLINE   = 8'd10;
   localparam logic [CHAR_W-1:0] CH_RETURN    = 8'd13;
   localparam logic [CHAR_W-1:0] CH_BLANK     = 8'h20;

   localparam logic [ATTR_W-1:0] RESET_ATTR = 8'h0F;

   typedef enum logic [3:0] {
      OP_PRINT,
      OP_NEWLINE,
      OP_RETURN,
      OP_BACKSPACE,
      OP_TAB,
      OP_SETPOS,
      OP_CLEAR,
      OP_INSERT,
      OP_DELETE,
      OP_READ,
      OP_NOP
   } tcce_op_type;

   typedef struct packed {
      tcce_op_type         op;
      logic [CHAR_W-1:0]   ch;
      logic [COL_W-1:0]    col;
      logic [ROW_W-1:0]    row;
      logic                read_ok;
   } tcce_cmd_type;

   typedef enum logic [1:0] {
      ST_IDLE,
      ST_SWEEP,
      ST_FLUSH,
      ST_RESULT
   } tcce_state_type;

endpackage

// ===== rtl/core/tcce_if.sv =====
`timescale 1ns / 1ps

interface tcce_req_if import tcce_pkg::*; ();
   logic              valid;
   logic              ready;
   logic [CMD_W-1:0]  command;
   logic [CHAR_W-1:0] char_code;
   logic [POS_W-1:0]  col;
   logic [POS_W-1:0]  row;

   modport source (output valid, command, char_code, col, row, input ready);
   modport sink (input valid, command, char_code, col, row, output ready);
endinterface

interface tcce_rsp_if import tcce_pkg::*; ();
   logic                 valid;
   logic                 ready;
   logic [OUT_COL_W-1:0] cursor_col_out;
   logic [OUT_ROW_W-1:0] cursor_row_out;
   logic [OUT_LIN_W-1:0] cursor_linear;
   logic [CHAR_W-1:0]    read_char;

   modport source (output valid, cursor_col_out, cursor_row_out, cursor_linear, read_char,
                   input ready);
   modport sink (input valid, cursor_col_out, cursor_row_out, cursor_linear, read_char,
                 output ready);
endinterface

interface tcce_csr_if import tcce_pkg::*; ();
   logic              valid;
   logic              ready;
   logic [ATTR_W-1:0] text_attribute;

   modport source (output valid, text_attribute, input ready);
   modport sink (input valid, text_attribute, output ready);
endinterface

// ===== rtl/core/tcce_front.sv =====
`timescale 1ns / 1ps

module tcce_front import tcce_pkg::*; #(
   parameter int COLUMNS = COLUMNS_DEF,
   parameter int ROWS    = ROWS_DEF
) (
   input  logic         clock,
   input  logic         reset,
   input  logic         hold,
   tcce_req_if.sink     req_ch,
   output logic         push_valid,
   output tcce_cmd_type push_data,
   input  logic         push_ready
);

   logic         stage_valid_ff;
   logic         stage_valid_in;
   tcce_cmd_type stage_cmd_ff;
   tcce_cmd_type stage_cmd_in;
   logic         req_fire;
   logic         col_over;
   logic         row_over;

   assign req_ch.ready = !hold && (!stage_valid_ff || push_ready);
   assign req_fire     = req_ch.valid && req_ch.ready;
   assign push_valid   = stage_valid_ff;
   assign push_data    = stage_cmd_ff;

   assign col_over = req_ch.col >= POS_W'(COLUMNS);
   assign row_over = req_ch.row >= POS_W'(ROWS);

   // decode the command and clamp the position once, up front
   always_comb begin
      stage_cmd_in = stage_cmd_ff;
      if (req_fire) begin
         stage_cmd_in.ch      = req_ch.char_code;
         stage_cmd_in.col     = col_over ? COL_W'(COLUMNS - 1) : req_ch.col[COL_W-1:0];
         stage_cmd_in.row     = row_over ? ROW_W'(ROWS - 1) : req_ch.row[ROW_W-1:0];
         stage_cmd_in.read_ok = !col_over && !row_over;
         case (req_ch.command)
            CMD_PUT: begin
               case (req_ch.char_code)
                  CH_NEWLINE:   stage_cmd_in.op = OP_NEWLINE;
                  CH_RETURN:    stage_cmd_in.op = OP_RETURN;
                  CH_BACKSPACE: stage_cmd_in.op = OP_BACKSPACE;
                  CH_TAB:       stage_cmd_in.op = OP_TAB;
                  default:      stage_cmd_in.op = OP_PRINT;
               endcase
            end
            CMD_SETPOS: stage_cmd_in.op = OP_SETPOS;
            CMD_CLEAR:  stage_cmd_in.op = OP_CLEAR;
            CMD_INSERT: stage_cmd_in.op = OP_INSERT;
            CMD_DELETE: stage_cmd_in.op = OP_DELETE;
            CMD_READ:   stage_cmd_in.op = OP_READ;
            default:    stage_cmd_in.op = OP_NOP;
         endcase
      end
   end

   always_comb begin
      if (req_fire) begin
         stage_valid_in = 1'b1;
      end else if (push_ready) begin
         stage_valid_in = 1'b0;
      end else begin
         stage_valid_in = stage_valid_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         stage_valid_ff <= 1'b0;
      end else begin
         stage_valid_ff <= stage_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      stage_cmd_ff <= stage_cmd_in;
   end

endmodule

// ===== rtl/core/tcce_queue.sv =====
`timescale 1ns / 1ps

module tcce_queue import tcce_pkg::*; #(
   parameter int DEPTH = QUEUE_DEPTH_DEF
) (
   input  logic         clock,
   input  logic         reset,
   input  logic         push_valid,
   input  tcce_cmd_type push_data,
   output logic         push_ready,
   output logic         pop_valid,
   output tcce_cmd_type pop_data,
   input  logic         pop_ready
);

   localparam int PTR_W = $clog2(DEPTH);
   localparam int CNT_W = $clog2(DEPTH + 1);

   tcce_cmd_type     entry_ff [DEPTH];
   logic [PTR_W-1:0] wr_ptr_ff;
   logic [PTR_W-1:0] wr_ptr_in;
   logic [PTR_W-1:0] rd_ptr_ff;
   logic [PTR_W-1:0] rd_ptr_in;
   logic [CNT_W-1:0] count_ff;
   logic [CNT_W-1:0] count_in;
   logic             push_fire;
   logic             pop_fire;

   assign push_ready = count_ff != CNT_W'(DEPTH);
   assign pop_valid  = count_ff != '0;
   assign pop_data   = entry_ff[rd_ptr_ff];
   assign push_fire  = push_valid && push_ready;
   assign pop_fire   = pop_valid && pop_ready;

   always_comb begin
      wr_ptr_in = wr_ptr_ff;
      rd_ptr_in = rd_ptr_ff;
      if (push_fire) begin
         wr_ptr_in = (wr_ptr_ff == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr_ff + PTR_W'(1);
      end
      if (pop_fire) begin
         rd_ptr_in = (rd_ptr_ff == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr_ff + PTR_W'(1);
      end
      case ({push_fire, pop_fire})
         2'b10:   count_in = count_ff + CNT_W'(1);
         2'b01:   count_in = count_ff - CNT_W'(1);
         default: count_in = count_ff;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (push_fire) begin
         entry_ff[wr_ptr_ff] <= push_data;
      end
   end

endmodule

// ===== rtl/core/tcce_back.sv =====
`timescale 1ns / 1ps

module tcce_back import tcce_pkg::*; #(
   parameter int COLUMNS  = COLUMNS_DEF,
   parameter int ROWS     = ROWS_DEF,
   parameter int TAB_STOP = TAB_STOP_DEF
) (
   input  logic         clock,
   input  logic         reset,
   tcce_csr_if.sink     csr_ch,
   input  logic         pop_valid,
   input  tcce_cmd_type pop_data,
   output logic         pop_ready,
   output logic         init_busy,
   tcce_rsp_if.source   rsp_ch
);

   localparam int CELLS    = COLUMNS * ROWS;
   localparam int CELL_AW  = $clog2(CELLS);
   localparam int LIM_W    = CELL_AW + 1;
   localparam int NCOL_W   = COL_W + 1;
   localparam int NROW_W   = ROW_W + 1;
   localparam int TAB_SPAN = 1 << COL_W;

   tcce_state_type state_ff;
   tcce_state_type state_in;

   logic [ATTR_W-1:0]    attr_ff;
   logic [ATTR_W-1:0]    attr_in;
   logic [COL_W-1:0]     ccol_ff;
   logic [COL_W-1:0]     ccol_in;
   logic [ROW_W-1:0]     crow_ff;
   logic [ROW_W-1:0]     crow_in;
   logic [CELL_AW-1:0]   addr_ff;
   logic [CELL_AW-1:0]   addr_in;
   logic [CELL_AW-1:0]   end_ff;
   logic [CELL_AW-1:0]   end_in;
   logic [LIM_W-1:0]     lim_ff;
   logic [LIM_W-1:0]     lim_in;
   logic                 down_ff;
   logic                 down_in;
   logic                 init_ff;
   logic                 init_in;
   logic                 pend_ff;
   logic                 pend_in;
   logic [CELL_AW-1:0]   pend_addr_ff;
   logic [CELL_AW-1:0]   pend_addr_in;
   logic                 pend_copy_ff;
   logic                 pend_copy_in;
   logic                 res_read_ff;
   logic                 res_read_in;
   logic                 rsp_valid_ff;
   logic                 rsp_valid_in;
   logic [OUT_COL_W-1:0] out_col_ff;
   logic [OUT_ROW_W-1:0] out_row_ff;
   logic [OUT_LIN_W-1:0] out_lin_ff;
   logic [CHAR_W-1:0]    out_char_ff;
   logic                 out_load;
   logic [CELL_W-1:0]    rd_data_ff;

   logic [CELL_W-1:0]    screen_mem [CELLS];

   logic [NCOL_W-1:0]    tab_next [TAB_SPAN];

   logic                 pop_fire;
   logic                 out_free;
   logic                 put_op;
   logic [CELL_AW-1:0]   row_base;
   logic [CELL_AW-1:0]   cur_addr;
   logic [CELL_AW-1:0]   read_addr;
   logic [NCOL_W-1:0]    ncol;
   logic [NROW_W-1:0]    nrow;
   logic                 scroll;
   logic                 cell_we;
   logic [CELL_AW-1:0]   cell_addr;
   logic [CELL_W-1:0]    cell_data;
   logic [CELL_W-1:0]    fill_cell;
   logic                 sweep_copy;
   logic [CELL_AW-1:0]   sweep_src;
   logic                 mem_we;
   logic [CELL_AW-1:0]   mem_waddr;
   logic [CELL_W-1:0]    mem_wdata;
   logic                 mem_re;
   logic [CELL_AW-1:0]   mem_raddr;

   // next tab stop for every column, built at elaboration
   for (genvar gi = 0; gi < TAB_SPAN; gi++) begin : g_tab
      assign tab_next[gi] = NCOL_W'(gi + TAB_STOP - ((gi + TAB_STOP) % TAB_STOP));
   end

   assign csr_ch.ready = 1'b1;
   assign attr_in      = (csr_ch.valid && csr_ch.ready) ? csr_ch.text_attribute : attr_ff;

   assign pop_ready = (state_ff == ST_IDLE);
   assign pop_fire  = pop_valid && pop_ready;
   assign out_free  = !rsp_valid_ff || rsp_ch.ready;
   assign init_busy = init_ff;

   assign rsp_ch.valid          = rsp_valid_ff;
   assign rsp_ch.cursor_col_out = out_col_ff;
   assign rsp_ch.cursor_row_out = out_row_ff;
   assign rsp_ch.cursor_linear  = out_lin_ff;
   assign rsp_ch.read_char      = out_char_ff;

   assign row_base  = CELL_AW'(crow_ff * COLUMNS);
   assign cur_addr  = row_base + CELL_AW'(ccol_ff);
   assign read_addr = CELL_AW'(pop_data.row * COLUMNS) + CELL_AW'(pop_data.col);
   assign fill_cell = init_ff ? {RESET_ATTR, CH_BLANK} : {attr_ff, CH_BLANK};

   assign sweep_copy = down_ff ? ({1'b0, addr_ff} >= lim_ff) : ({1'b0, addr_ff} < lim_ff);
   assign sweep_src  = down_ff ? addr_ff - CELL_AW'(COLUMNS) : addr_ff + CELL_AW'(COLUMNS);

   assign put_op = (pop_data.op == OP_PRINT) || (pop_data.op == OP_NEWLINE) ||
                   (pop_data.op == OP_RETURN) || (pop_data.op == OP_BACKSPACE) ||
                   (pop_data.op == OP_TAB);

   // cursor motion and cell write of a put character
   always_comb begin
      ncol      = NCOL_W'(ccol_ff);
      nrow      = NROW_W'(crow_ff);
      cell_we   = 1'b0;
      cell_addr = cur_addr;
      cell_data = {attr_ff, pop_data.ch};
      scroll    = 1'b0;
      case (pop_data.op)
         OP_NEWLINE: begin
            ncol = '0;
            nrow = nrow + NROW_W'(1);
         end
         OP_RETURN: begin
            ncol = '0;
         end
         OP_BACKSPACE: begin
            if (ccol_ff != '0) begin
               ncol      = ncol - NCOL_W'(1);
               cell_we   = 1'b1;
               cell_addr = cur_addr - CELL_AW'(1);
               cell_data = {attr_ff, CH_BLANK};
            end
         end
         OP_TAB: begin
            ncol = tab_next[ccol_ff];
         end
         OP_PRINT: begin
            cell_we = 1'b1;
            ncol    = ncol + NCOL_W'(1);
         end
         default: begin
         end
      endcase
      if (ncol >= NCOL_W'(COLUMNS)) begin
         ncol = '0;
         nrow = nrow + NROW_W'(1);
      end
      if (nrow >= NROW_W'(ROWS)) begin
         scroll = 1'b1;
         nrow   = NROW_W'(ROWS - 1);
      end
   end

   // next state
   always_comb begin
      state_in = state_ff;
      case (state_ff)
         ST_IDLE: begin
            if (pop_fire) begin
               case (pop_data.op)
                  OP_CLEAR, OP_INSERT, OP_DELETE: state_in = ST_SWEEP;
                  default:                        state_in = (put_op && scroll) ? ST_SWEEP
                                                                                : ST_RESULT;
               endcase
            end
         end
         ST_SWEEP: begin
            if (addr_ff == end_ff) begin
               state_in = ST_FLUSH;
            end
         end
         ST_FLUSH: begin
            state_in = init_ff ? ST_IDLE : ST_RESULT;
         end
         ST_RESULT: begin
            if (out_free) begin
               state_in = ST_IDLE;
            end
         end
         default: state_in = ST_IDLE;
      endcase
   end

   // datapath and memory port control
   always_comb begin
      ccol_in      = ccol_ff;
      crow_in      = crow_ff;
      addr_in      = addr_ff;
      end_in       = end_ff;
      lim_in       = lim_ff;
      down_in      = down_ff;
      init_in      = init_ff;
      pend_in      = pend_ff;
      pend_addr_in = pend_addr_ff;
      pend_copy_in = pend_copy_ff;
      res_read_in  = res_read_ff;
      out_load     = 1'b0;
      mem_we       = 1'b0;
      mem_waddr    = pend_addr_ff;
      mem_wdata    = pend_copy_ff ? rd_data_ff : fill_cell;
      mem_re       = 1'b0;
      mem_raddr    = sweep_src;
      case (state_ff)
         ST_IDLE: begin
            if (pop_fire) begin
               res_read_in = 1'b0;
               case (pop_data.op)
                  OP_PRINT, OP_NEWLINE, OP_RETURN, OP_BACKSPACE, OP_TAB: begin
                     ccol_in   = COL_W'(ncol);
                     crow_in   = ROW_W'(nrow);
                     mem_we    = cell_we;
                     mem_waddr = cell_addr;
                     mem_wdata = cell_data;
                     addr_in   = '0;
                     end_in    = CELL_AW'(CELLS - 1);
                     down_in   = 1'b0;
                     lim_in    = LIM_W'(CELLS - COLUMNS);
                  end
                  OP_SETPOS: begin
                     ccol_in = pop_data.col;
                     crow_in = pop_data.row;
                  end
                  OP_CLEAR: begin
                     ccol_in = '0;
                     crow_in = '0;
                     addr_in = '0;
                     end_in  = CELL_AW'(CELLS - 1);
                     down_in = 1'b0;
                     lim_in  = '0;
                  end
                  OP_INSERT: begin
                     addr_in = CELL_AW'(CELLS - 1);
                     end_in  = row_base;
                     down_in = 1'b1;
                     lim_in  = LIM_W'(row_base) + LIM_W'(COLUMNS);
                  end
                  OP_DELETE: begin
                     addr_in = row_base;
                     end_in  = CELL_AW'(CELLS - 1);
                     down_in = 1'b0;
                     lim_in  = LIM_W'(CELLS - COLUMNS);
                  end
                  OP_READ: begin
                     res_read_in = pop_data.read_ok;
                     mem_re      = pop_data.read_ok;
                     mem_raddr   = read_addr;
                  end
                  default: begin
                  end
               endcase
            end
         end
         ST_SWEEP: begin
            // write the cell fetched last cycle, fetch the source of this one
            mem_we       = pend_ff;
            mem_re       = sweep_copy;
            pend_in      = 1'b1;
            pend_addr_in = addr_ff;
            pend_copy_in = sweep_copy;
            if (addr_ff != end_ff) begin
               addr_in = down_ff ? addr_ff - CELL_AW'(1) : addr_ff + CELL_AW'(1);
            end
         end
         ST_FLUSH: begin
            mem_we  = pend_ff;
            pend_in = 1'b0;
            init_in = 1'b0;
         end
         ST_RESULT: begin
            out_load = out_free;
         end
         default: begin
         end
      endcase
   end

   always_comb begin
      if (out_load) begin
         rsp_valid_in = 1'b1;
      end else if (rsp_ch.ready) begin
         rsp_valid_in = 1'b0;
      end else begin
         rsp_valid_in = rsp_valid_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_SWEEP;
         attr_ff      <= RESET_ATTR;
         ccol_ff      <= '0;
         crow_ff      <= '0;
         addr_ff      <= '0;
         end_ff       <= CELL_AW'(CELLS - 1);
         lim_ff       <= '0;
         down_ff      <= 1'b0;
         init_ff      <= 1'b1;
         pend_ff      <= 1'b0;
         res_read_ff  <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         attr_ff      <= attr_in;
         ccol_ff      <= ccol_in;
         crow_ff      <= crow_in;
         addr_ff      <= addr_in;
         end_ff       <= end_in;
         lim_ff       <= lim_in;
         down_ff      <= down_in;
         init_ff      <= init_in;
         pend_ff      <= pend_in;
         res_read_ff  <= res_read_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      pend_addr_ff <= pend_addr_in;
      pend_copy_ff <= pend_copy_in;
      if (out_load) begin
         out_col_ff  <= OUT_COL_W'(ccol_ff);
         out_row_ff  <= OUT_ROW_W'(crow_ff);
         out_lin_ff  <= OUT_LIN_W'(crow_ff * COLUMNS + ccol_ff);
         out_char_ff <= res_read_ff ? rd_data_ff[CHAR_W-1:0] : '0;
      end
   end

   // screen store, one write and one registered read per cycle
   always_ff @(posedge clock) begin
      if (mem_we) begin
         screen_mem[mem_waddr] <= mem_wdata;
      end
      if (mem_re) begin
         rd_data_ff <= screen_mem[mem_raddr];
      end
   end

   a_init_quiet: assert property (@(posedge clock) disable iff (reset)
      init_ff |-> !rsp_valid_ff && !pop_fire)
      else $error("transaction activity during the clearing pass");

   a_cursor_range: assert property (@(posedge clock) disable iff (reset)
      ({1'b0, ccol_ff} < NCOL_W'(COLUMNS)) && ({1'b0, crow_ff} < NROW_W'(ROWS)))
      else $error("cursor outside the screen");

   a_sweep_range: assert property (@(posedge clock) disable iff (reset)
      state_ff == ST_SWEEP |-> {1'b0, addr_ff} < LIM_W'(CELLS))
      else $error("sweep address outside the screen");

   a_idle_drained: assert property (@(posedge clock) disable iff (reset)
      state_ff == ST_IDLE |-> !pend_ff)
      else $error("cell write left pending at idle");

   a_result_lands: assert property (@(posedge clock) disable iff (reset)
      (state_ff == ST_RESULT && out_free) |=> rsp_valid_ff && state_ff == ST_IDLE)
      else $error("result not presented");

endmodule

// ===== rtl/core/text_console_char_engine.sv =====
// path: a command is registered in the front stage, passes the queue, is executed by
//   the engine and is presented from its output register; clear and scrolling put also
//   walk the whole screen store, insert and delete the rows from the cursor row down
// commands: the engine takes the next command only once it is idle again, so a
//   full-screen command holds the queue while its walk visits one cell per cycle
// reset: synchronous; cursor to 0,0, attribute 0x0F, then a clearing pass
//   fills the store with blanks while no request is accepted
`timescale 1ns / 1ps

module text_console_char_engine import tcce_pkg::*; #(
   parameter int COLUMNS     = COLUMNS_DEF,
   parameter int ROWS        = ROWS_DEF,
   parameter int TAB_STOP    = TAB_STOP_DEF,
   parameter int QUEUE_DEPTH = QUEUE_DEPTH_DEF
) (
   input  logic       clock,
   input  logic       reset,
   tcce_req_if.sink   req_ch,
   tcce_rsp_if.source rsp_ch,
   tcce_csr_if.sink   csr_ch
);

   // front stage to queue
   logic         push_valid;
   logic         push_ready;
   tcce_cmd_type push_data;

   // queue to execution engine
   logic         pop_valid;
   logic         pop_ready;
   tcce_cmd_type pop_data;

   // high while the store is being blanked after reset
   logic         init_busy;

   // front: takes a request transaction, decodes the command and control
   // characters, clamps the position and flags reads that fall off the screen
   tcce_front #(
      .COLUMNS (COLUMNS),
      .ROWS    (ROWS)
   ) u_front (
      .clock      (clock),
      .reset      (reset),
      .hold       (init_busy),
      .req_ch     (req_ch),
      .push_valid (push_valid),
      .push_data  (push_data),
      .push_ready (push_ready)
   );

   // short command queue so the front keeps taking requests while the
   // engine walks the screen store
   tcce_queue #(
      .DEPTH (QUEUE_DEPTH)
   ) u_queue (
      .clock      (clock),
      .reset      (reset),
      .push_valid (push_valid),
      .push_data  (push_data),
      .push_ready (push_ready),
      .pop_valid  (pop_valid),
      .pop_data   (pop_data),
      .pop_ready  (pop_ready)
   );

   // back: owns the screen store, cursor and attribute register; single
   // cell writes go straight to the store, row copies and fills are a pipelined
   // sweep of it, and the result sits in an output register until the sink takes it
   tcce_back #(
      .COLUMNS  (COLUMNS),
      .ROWS     (ROWS),
      .TAB_STOP (TAB_STOP)
   ) u_back (
      .clock     (clock),
      .reset     (reset),
      .csr_ch    (csr_ch),
      .pop_valid (pop_valid),
      .pop_data  (pop_data),
      .pop_ready (pop_ready),
      .init_busy (init_busy),
      .rsp_ch    (rsp_ch)
   );

endmodule
